/* sv/miwo_pkg.sv */
// Package for the MP3 IMDCT / window / overlap-add block.
// Holds sizes, the Q14 cosine table, window and coefficient helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package miwo_pkg;

    localparam int SUBBANDS    = 32;
    localparam int LINES       = 18;
    localparam int CHANNELS    = 2;
    localparam int BLOCK_LEN   = 2 * LINES;
    localparam int STORE_DEPTH = CHANNELS * SUBBANDS * LINES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SB_W        = (SUBBANDS > 1) ? $clog2(SUBBANDS) : 1;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LINE_W      = 16;
    localparam int SAMPLE_W    = 17;
    localparam int ACC_W       = 36;
    localparam int PROD_W      = ACC_W + LINE_W;
    localparam int BLK_W       = 26;
    localparam int FRAC_SHIFT  = 28;

    // block type codes
    localparam logic [1:0] BT_NORMAL = 2'd0;
    localparam logic [1:0] BT_START  = 2'd1;
    localparam logic [1:0] BT_SHORT  = 2'd2;
    localparam logic [1:0] BT_STOP   = 2'd3;

    // configuration register indexes
    localparam logic CFG_BLOCK_TYPE = 1'b0;
    localparam logic CFG_CHANNEL    = 1'b1;

    // cos(pi*j/72), j = 0..36, Q14
    localparam logic [14:0] COS_TAB [37] = '{
        15'd16384, 15'd16368, 15'd16322, 15'd16244, 15'd16135, 15'd15996,
        15'd15826, 15'd15626, 15'd15396, 15'd15137, 15'd14849, 15'd14533,
        15'd14189, 15'd13818, 15'd13421, 15'd12998, 15'd12551, 15'd12080,
        15'd11585, 15'd11069, 15'd10531, 15'd9974,  15'd9397,  15'd8803,
        15'd8192,  15'd7565,  15'd6924,  15'd6270,  15'd5604,  15'd4927,
        15'd4241,  15'd3546,  15'd2845,  15'd2139,  15'd1428,  15'd715,
        15'd0
    };

    // coefficient group start: phase index and zero flag
    typedef struct packed {
        logic       zero;
        logic [7:0] start;
    } t_grp;

    // chain cell control
    typedef struct packed {
        logic shift;
        logic fill;
    } t_cell_ctl;

    // cos(pi*m/72), m < 144
    function automatic logic signed [15:0] cos72(input logic [7:0] m);
        logic [7:0]         idx;
        logic               neg;
        logic signed [15:0] v;
        idx = 8'd36;
        neg = 1'b0;
        if (m <= 8'd36) begin
            idx = m;
        end else if (m <= 8'd72) begin
            idx = 8'd72 - m;
            neg = 1'b1;
        end else if (m <= 8'd108) begin
            idx = m - 8'd72;
            neg = 1'b1;
        end else if (m < 8'd144) begin
            idx = 8'd144 - m;
        end
        v = signed'({1'b0, COS_TAB[idx[5:0]]});
        return neg ? -v : v;
    endfunction

    // sin(pi*(2i+1)/72), i < 36
    function automatic logic signed [15:0] win_long(input logic [5:0] i);
        logic [5:0] j;
        j = (i <= 6'd17) ? 6'(6'd35 - 2 * i) : 6'(2 * i - 6'd35);
        return signed'({1'b0, COS_TAB[j]});
    endfunction

    // sin(pi*(2i+1)/24), i < 12; zero outside
    function automatic logic signed [15:0] win_short(input logic signed [6:0] i);
        logic [5:0] j;
        j = (i <= 7'sd5) ? 6'(33 - 6 * i) : 6'(6 * i - 33);
        if (i < 7'sd0 || i > 7'sd11) return '0;
        return signed'({1'b0, COS_TAB[j]});
    endfunction

    // window for the long-transform block types
    function automatic logic signed [15:0] win_for(input logic [1:0] bt,
                                                   input logic [5:0] i);
        logic signed [15:0] v;
        v = win_long(i);
        if (bt == BT_START) begin
            if (i >= 6'd30)      v = '0;
            else if (i >= 6'd24) v = win_short(7'(i - 6'd18));
            else if (i >= 6'd18) v = 16'sd16384;
        end else if (bt == BT_STOP) begin
            if (i < 6'd6)       v = '0;
            else if (i < 6'd12) v = win_short(7'(i - 6'd6));
            else if (i < 6'd18) v = 16'sd16384;
        end
        return v;
    endfunction

    // short window position of sample n in window w
    function automatic logic signed [6:0] short_pos(input logic [5:0] n,
                                                    input logic [1:0] w);
        return 7'(signed'({1'b0, n}) - 7'sd6 * signed'({5'b0, w} + 7'sd1));
    endfunction

    // first cosine phase of a coefficient group
    function automatic t_grp grp_start(input logic [5:0] n, input logic [1:0] w,
                                       input logic shrt);
        t_grp g;
        logic signed [6:0] i;
        i = short_pos(n, w);
        g.zero  = 1'b0;
        g.start = 8'(2 * n + 19);
        if (shrt) begin
            g.zero  = (i < 7'sd0) || (i > 7'sd11);
            g.start = g.zero ? 8'd0 : 8'(3 * (2 * i + 7));
        end
        return g;
    endfunction

    // phase advance per line: 2*start mod 144
    function automatic logic [7:0] grp_step(input logic [7:0] s);
        logic [8:0] d;
        d = {s, 1'b0};
        return (d >= 9'd144) ? 8'(d - 9'd144) : d[7:0];
    endfunction

    // saturate to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [BLK_W-1:0] v);
        if (v > BLK_W'(32767))  return 16'sd32767;
        if (v < -BLK_W'(32768)) return -16'sd32768;
        return v[15:0];
    endfunction

endpackage
`default_nettype wire

/* sv/miwo_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module miwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1152,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* sv/miwo_cell.sv */
// One cell of the line chain: holds one frequency line, takes its neighbor's.
// Depends on miwo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module miwo_cell (
    input  wire logic                    i_clk,
    input  wire miwo_pkg::t_cell_ctl     i_ctl,
    input  wire logic signed [15:0]      i_ext,
    input  wire logic signed [15:0]      i_nbr,
    output logic signed [15:0]           o_q
);
    logic signed [15:0] r_q;

    // shift from the neighbor, or load a new line at the chain end
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_q <= i_ctl.fill ? i_ext : i_nbr;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

/* sv/mp3_imdct_window_overlap_top.sv */
// Top level: line chain, shared MAC, window/round, overlap store, sequencer.
// Depends on miwo_pkg, miwo_cell, miwo_ram.
//
//  port group  | dir | tdata (low bit up)     | tlast           | tuser
//  s_axis      | in  | line_value[15:0]       | -               | -
//  m_axis      | out | time_sample[16:0], 0s  | last_of_subband | last_of_granule
//  i_cfg_*     | in  | idx 0 window type, 1 channel; data[1:0]
//
// Lines are taken one a cycle while idle. The 18th line of a subband starts the
// transform: each of the 36 block samples rotates the 18-cell chain once past
// the single MAC, plus window multiply and round per group and a setup step and
// a store/emit step per sample. After reset a clearing pass zeroes all 1152
// entries of the overlap store; no line is taken meanwhile. A stalled m_axis
// holds the sequencer in its emit step.
`timescale 1ns / 1ps
`default_nettype none
module mp3_imdct_window_overlap_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] line_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [16:0] time_sample, [23:17] zero
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,   // [0] last_of_granule
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [1:0]  i_cfg_data
);
    localparam int L = miwo_pkg::LINES;
    localparam int AW = miwo_pkg::ADDR_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_PREP, S_MAC, S_WIN, S_RND, S_EMIT, S_STORE
    } t_state;

    t_state r_state;
    logic [1:0]                     r_cfg_bt, r_bt;
    logic                           r_cfg_ch, r_ch;
    logic [4:0]                     r_cnt, r_k, r_j;
    logic                           r_half;
    logic [1:0]                     r_w;
    logic [7:0]                     r_m, r_step;
    logic                           r_zero;
    logic [miwo_pkg::SB_W-1:0]      r_sb;
    logic [AW-1:0]                  r_clr;
    logic signed [miwo_pkg::ACC_W-1:0]  r_acc;
    logic signed [miwo_pkg::PROD_W-1:0] r_prod;
    logic signed [miwo_pkg::BLK_W-1:0]  r_blk;
    logic                           r_oval, r_olast, r_ouser;
    logic signed [16:0]             r_osamp;

    logic                           w_accept, w_shrt, w_oslot;
    logic [5:0]                     w_n;
    logic signed [15:0]             w_q [L];
    logic signed [15:0]             w_coef, w_win, w_sat, w_ovl;
    logic signed [31:0]             w_mul;
    logic signed [miwo_pkg::PROD_W-1:0] w_wprod, w_rsum, w_rnd;
    miwo_pkg::t_grp                 w_g0, w_gn;
    miwo_pkg::t_cell_ctl            w_ctl_mid, w_ctl_end;
    logic [AW-1:0]                  w_addr;
    logic [15:0]                    w_rdata;
    logic                           w_ch_eff;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_shrt        = (r_bt == miwo_pkg::BT_SHORT);
    assign w_n           = r_half ? 6'(r_j + 5'd18) : {1'b0, r_j};
    assign w_oslot       = !r_oval || m_axis_tready;

    // line chain: shifts on each accepted line and on each MAC step
    assign w_ctl_mid.shift = w_accept || (r_state == S_MAC);
    assign w_ctl_mid.fill  = 1'b0;
    assign w_ctl_end.shift = w_ctl_mid.shift;
    assign w_ctl_end.fill  = (r_state == S_IDLE);

    for (genvar c = 0; c < L; c++) begin : g_chain
        if (c == L - 1) begin : g_end
            miwo_cell u_cell (
                .i_clk (i_clk), .i_ctl (w_ctl_end), .i_ext (s_axis_tdata),
                .i_nbr (w_q[0]), .o_q (w_q[c])
            );
        end else begin : g_mid
            miwo_cell u_cell (
                .i_clk (i_clk), .i_ctl (w_ctl_mid), .i_ext (s_axis_tdata),
                .i_nbr (w_q[c+1]), .o_q (w_q[c])
            );
        end
    end

    // coefficient, MAC product, window product and rounding
    assign w_coef  = r_zero ? 16'sd0 : miwo_pkg::cos72(r_m);
    assign w_mul   = w_q[0] * w_coef;
    assign w_win   = w_shrt ? miwo_pkg::win_short(miwo_pkg::short_pos(w_n, r_w))
                            : miwo_pkg::win_for(r_bt, w_n);
    assign w_wprod = miwo_pkg::PROD_W'(r_acc) * miwo_pkg::PROD_W'(w_win);
    assign w_rsum  = r_prod + (miwo_pkg::PROD_W'(1) <<< (miwo_pkg::FRAC_SHIFT - 1));
    assign w_rnd   = w_rsum >>> miwo_pkg::FRAC_SHIFT;
    assign w_sat   = miwo_pkg::sat16(r_blk);
    assign w_g0    = miwo_pkg::grp_start(w_n, 2'd0, w_shrt);
    assign w_gn    = miwo_pkg::grp_start(w_n, 2'(r_w + 2'd1), w_shrt);

    // overlap store address
    assign w_ch_eff = (int'(r_ch) < miwo_pkg::CHANNELS) ? r_ch : 1'b0;
    assign w_addr   = AW'(int'(w_ch_eff) * miwo_pkg::SUBBANDS * L + int'(r_sb) * L
                          + int'(r_j));
    assign w_ovl    = signed'(w_rdata);

    miwo_ram #(.WIDTH(16), .DEPTH(miwo_pkg::STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_CLEAR) || (r_state == S_STORE)),
        .i_waddr ((r_state == S_CLEAR) ? r_clr : w_addr),
        .i_wdata ((r_state == S_CLEAR) ? 16'd0 : w_sat),
        .i_re    ((r_state == S_PREP) && !r_half),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cfg_bt <= miwo_pkg::BT_NORMAL;
            r_cfg_ch <= 1'b0;
            r_cnt    <= '0;
            r_sb     <= '0;
            r_clr    <= '0;
            r_oval   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    miwo_pkg::CFG_BLOCK_TYPE: r_cfg_bt <= i_cfg_data;
                    miwo_pkg::CFG_CHANNEL:    r_cfg_ch <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // output valid: load on emit, drop once the beat is taken
            if ((r_state == S_EMIT) && w_oslot) begin
                r_oval <= 1'b1;
            end else if (m_axis_tready) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= AW'(r_clr + 1'b1);
                    if (int'(r_clr) == miwo_pkg::STORE_DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (int'(r_cnt) == L - 1) begin
                            r_cnt   <= '0;
                            r_bt    <= r_cfg_bt;
                            r_ch    <= r_cfg_ch;
                            r_j     <= '0;
                            r_half  <= 1'b0;
                            r_state <= S_PREP;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                S_PREP: begin
                    r_acc   <= '0;
                    r_blk   <= '0;
                    r_k     <= '0;
                    r_w     <= '0;
                    r_m     <= w_g0.start;
                    r_step  <= miwo_pkg::grp_step(w_g0.start);
                    r_zero  <= w_g0.zero;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_acc <= r_acc + miwo_pkg::ACC_W'(w_mul);
                    r_m   <= (9'(r_m) + 9'(r_step) >= 9'd144)
                             ? 8'(9'(r_m) + 9'(r_step) - 9'd144) : 8'(r_m + r_step);
                    r_k   <= r_k + 5'd1;
                    if (r_k == 5'd17 || (w_shrt && (r_k == 5'd5 || r_k == 5'd11))) begin
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    r_prod  <= w_wprod;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_blk <= r_blk + miwo_pkg::BLK_W'(w_rnd);
                    if (int'(r_k) == L) begin
                        r_state <= r_half ? S_STORE : S_EMIT;
                    end else begin
                        r_acc   <= '0;
                        r_w     <= 2'(r_w + 2'd1);
                        r_m     <= w_gn.start;
                        r_step  <= miwo_pkg::grp_step(w_gn.start);
                        r_zero  <= w_gn.zero;
                        r_state <= S_MAC;
                    end
                end
                S_EMIT: begin
                    if (w_oslot) begin
                        r_osamp <= 17'(w_sat) + 17'(w_ovl);
                        r_olast <= (int'(r_j) == L - 1);
                        r_ouser <= (int'(r_j) == L - 1)
                                   && (int'(r_sb) == miwo_pkg::SUBBANDS - 1);
                        r_half  <= 1'b1;
                        r_state <= S_PREP;
                    end
                end
                S_STORE: begin
                    r_half <= 1'b0;
                    if (int'(r_j) == L - 1) begin
                        r_sb    <= (int'(r_sb) == miwo_pkg::SUBBANDS - 1)
                                   ? '0 : miwo_pkg::SB_W'(r_sb + 1'b1);
                        r_state <= S_IDLE;
                    end else begin
                        r_j     <= r_j + 5'd1;
                        r_state <= S_PREP;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {7'd0, r_osamp};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;
endmodule
`default_nettype wire

/* sv/miwo_chk.sv */
// Port-level checker for the IMDCT / overlap-add top, with its bind.
// Depends on mp3_imdct_window_overlap_top.
`timescale 1ns / 1ps
`default_nettype none
module miwo_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser
);
    // reset starts the clearing pass: no line taken next cycle
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !s_axis_tready)
        else $error("line accepted right after reset");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // end of granule only on the end of a subband
    a_gran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("granule end without subband end");

    // padding above the sample stays zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:17] == 7'd0))
        else $error("nonzero tdata padding");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output beat changed");
endmodule

bind mp3_imdct_window_overlap_top miwo_chk u_miwo_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

/* test/miwo_checker.sv */
// Result checker for the MP3 IMDCT / window / overlap-add block.
// Watches line beats, config writes and sample beats, predicts and compares.
// Depends on miwo_pkg for sizes, block type codes, register indexes and the cosine table.
`timescale 1ns / 1ps
module miwo_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [1:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [16:0] sample;
        logic        sb_last;
        logic        gr_last;
    } t_sample;

    t_sample            sample_q[$];
    logic signed [15:0] line_buf [miwo_pkg::LINES];
    logic signed [15:0] overlap_mem [miwo_pkg::STORE_DEPTH];
    logic [1:0]         cur_bt;
    logic               cur_ch;
    int                 fill_cnt;
    int                 sb_idx;

    // cos(pi*m/72) in Q14
    function automatic longint phase_cos(input int m);
        m = m % 144;
        if (m <= 36) return longint'(miwo_pkg::COS_TAB[m]);
        if (m <= 72) return -longint'(miwo_pkg::COS_TAB[72 - m]);
        if (m <= 108) return -longint'(miwo_pkg::COS_TAB[m - 72]);
        return longint'(miwo_pkg::COS_TAB[144 - m]);
    endfunction

    function automatic longint long_win(input int i);
        return longint'(miwo_pkg::COS_TAB[(i <= 17) ? 35 - 2 * i : 2 * i - 35]);
    endfunction

    function automatic longint short_win(input int i);
        return longint'(miwo_pkg::COS_TAB[(i <= 5) ? 33 - 6 * i : 6 * i - 33]);
    endfunction

    // window shape per long-transform block type
    function automatic longint block_win(input logic [1:0] bt, input int i);
        if (bt == miwo_pkg::BT_START) begin
            if (i < 18) return long_win(i);
            if (i < 24) return 16384;
            if (i < 30) return short_win(i - 18);
            return 0;
        end
        if (bt == miwo_pkg::BT_STOP) begin
            if (i < 6) return 0;
            if (i < 12) return short_win(i - 6);
            if (i < 18) return 16384;
        end
        return long_win(i);
    endfunction

    // Q28 -> Q0, nearest, ties up
    function automatic longint round_q14(input longint v);
        return (v + (longint'(1) <<< 27)) >>> 28;
    endfunction

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // transform, window and overlap-add one full subband of lines
    task automatic predict_subband();
        longint acc;
        longint blk [miwo_pkg::BLOCK_LEN];
        longint s;
        int base;
        t_sample e;
        for (int i = 0; i < miwo_pkg::BLOCK_LEN; i++) blk[i] = 0;
        if (cur_bt == miwo_pkg::BT_SHORT) begin
            for (int w = 0; w < 3; w++) begin
                for (int i = 0; i < 12; i++) begin
                    acc = 0;
                    for (int k = 0; k < 6; k++)
                        acc += longint'(line_buf[6 * w + k]) *
                               phase_cos(3 * (2 * i + 7) * (2 * k + 1));
                    blk[6 + 6 * w + i] += round_q14(acc * short_win(i));
                end
            end
        end else begin
            for (int i = 0; i < miwo_pkg::BLOCK_LEN; i++) begin
                acc = 0;
                for (int k = 0; k < miwo_pkg::LINES; k++)
                    acc += longint'(line_buf[k]) * phase_cos((2 * i + 19) * (2 * k + 1));
                blk[i] = round_q14(acc * block_win(cur_bt, i));
            end
        end
        base = (int'(cur_ch) * miwo_pkg::SUBBANDS + sb_idx) * miwo_pkg::LINES;
        for (int i = 0; i < miwo_pkg::LINES; i++) begin
            s = clip16(blk[i]) + longint'(overlap_mem[base + i]);
            overlap_mem[base + i] = 16'(clip16(blk[miwo_pkg::LINES + i]));
            e.sample  = 17'(s);
            e.sb_last = (i == miwo_pkg::LINES - 1);
            e.gr_last = (i == miwo_pkg::LINES - 1) && (sb_idx == miwo_pkg::SUBBANDS - 1);
            sample_q.push_back(e);
        end
        sb_idx = (sb_idx == miwo_pkg::SUBBANDS - 1) ? 0 : sb_idx + 1;
    endtask

    // watch all channels at each edge
    always @(posedge i_clk) begin
        t_sample e;
        if (!i_rst_n) begin
            cur_bt   = miwo_pkg::BT_NORMAL;
            cur_ch   = 1'b0;
            fill_cnt = 0;
            sb_idx   = 0;
            for (int i = 0; i < miwo_pkg::STORE_DEPTH; i++) overlap_mem[i] = '0;
            sample_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == miwo_pkg::CFG_BLOCK_TYPE) cur_bt = i_cfg_data;
                else cur_ch = i_cfg_data[0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                line_buf[fill_cnt] = s_axis_tdata;
                fill_cnt++;
                if (fill_cnt == miwo_pkg::LINES) begin
                    fill_cnt = 0;
                    predict_subband();
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (sample_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%t: unexpected sample beat %h", $realtime, m_axis_tdata);
                    o_fail_count++;
                end else begin
                    e = sample_q.pop_front();
                    if (m_axis_tdata !== {7'b0, e.sample} || m_axis_tlast !== e.sb_last ||
                        m_axis_tuser !== e.gr_last) begin
                        if (o_fail_count < 10)
                            $display("%t: mismatch exp data %h last %b user %b, got %h %b %b",
                                     $realtime, {7'b0, e.sample}, e.sb_last, e.gr_last,
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = sample_q.size();
    end

endmodule

/* test/tb_top.sv */
// Stimulus and verdict for the MP3 IMDCT / window / overlap-add block.
// Depends on miwo_pkg, mp3_imdct_window_overlap_top and miwo_checker.
`timescale 1ns / 1ps
module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [1:0]  i_cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_cnt;
    int          stall_left;
    bit          calm;

    mp3_imdct_window_overlap_top DUT (.*);

    miwo_checker u_checker (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 2000000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // sample side backpressure: short stalls, rare long ones, calm stretches
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 199) == 0) calm <= ~calm;
            if (!calm && $urandom_range(0, 5) == 0)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                           : $urandom_range(1, 3);
        end
    end

    // one line beat, with an optional gap ahead of it
    task automatic send_line(input logic [15:0] v, input logic no_gap);
        int gap;
        gap = 0;
        if (!no_gap && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // hold off until every sample is out and the block is idle again
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] bt, input logic [1:0] ch);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= miwo_pkg::CFG_BLOCK_TYPE;
        i_cfg_data <= bt;
        @(posedge i_clk);
        i_cfg_idx  <= miwo_pkg::CFG_CHANNEL;
        i_cfg_data <= ch;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [15:0] pick_line(input int kind, input int k, input int hot);
        case (kind)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 1023) - 512);
            2: begin
                case ($urandom_range(0, 2))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    default: return 16'h0000;
                endcase
            end
            default: return (k == hot) ? 16'($urandom) : 16'h0000;
        endcase
    endfunction

    initial begin
        int kind;
        int hot;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = miwo_pkg::CFG_BLOCK_TYPE;
        i_cfg_data    = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-scale positive, full-scale negative and zero lines
        write_cfg(miwo_pkg::BT_NORMAL, 2'd0);
        for (int k = 0; k < miwo_pkg::LINES; k++)
            send_line((k < 6) ? 16'h7fff : (k < 12) ? 16'h8000 : 16'h0000, k < 6);
        drain();

        // random subbands; the first eight walk every block type on both channels
        for (int n = 0; n < 20; n++) begin
            if (n < 8) write_cfg(2'(n % 4), 2'(n / 4));
            else write_cfg(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            kind = (n < 4) ? 2 : $urandom_range(0, 3);
            hot  = $urandom_range(0, miwo_pkg::LINES - 1);
            for (int k = 0; k < miwo_pkg::LINES; k++)
                send_line(pick_line(kind, k, hot), n % 3 == 0);
            drain();
        end

        if (fail_count == 0 && pending == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
